[design/plfe_pkg.sv]
// Shared types and constants of the prefixed line frame extractor.
// Used by plfe_line_ram, plfe_ctrl and prefixed_line_frame_extractor.
package plfe_pkg;

    // Line store geometry
    localparam int unsigned LINE_MAX   = 64;
    localparam int unsigned ADDR_W     = $clog2(LINE_MAX);
    localparam int unsigned LEN_W      = $clog2(LINE_MAX + 1);

    // Register widths
    localparam int unsigned PREFIX_MAX = 8;
    localparam int unsigned MATCH_W    = 4;
    localparam int unsigned PLEN_W     = 4;
    localparam int unsigned SYNC_W     = 8;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    // Line characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX_BYTES  = 2'd0,
        CFG_PREFIX_LENGTH = 2'd1,
        CFG_SYNC_LENGTH   = 2'd2
    } cfg_idx_t;

    // Result event codes
    typedef enum logic [1:0] {
        KIND_FRAME    = 2'd0,
        KIND_OVERLONG = 2'd1,
        KIND_SYNC     = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CFG_W-1:0]  prefix_bytes;
        logic [PLEN_W-1:0] prefix_length;
        logic [SYNC_W-1:0] sync_length;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last;
    } beat_t;

endpackage

[design/prefixed_line_frame_extractor.sv]
// Top level of the prefixed line frame extractor: configuration registers,
// the line store RAM and the sequencer. Depends on plfe_pkg, plfe_line_ram, plfe_ctrl.
//
// One byte beat is taken while the block is idle. A zero byte is decided and then
// goes back to idle, or to the event step for the sync beat if it completes a sync
// run. Any other byte is decided and parsed, after one replay step per held-back
// zero of a short run; each replayed zero is parsed and may be written through the
// single write port of the line store. A newline that closes a frame passes the CR
// check, then its payload beats are read one per cycle (with m_tready high) from the
// line store. An empty frame goes to the event step, after the CR check when a lone
// carriage return is dropped; an overlong frame goes straight there. Empty, overlong
// and sync events are one beat each. A finished beat waits in the output register
// while the next input beat is taken. A low m_tready holds the block once a second
// beat is ready. m_tlast marks the final result beat of an input byte. m_tuser carries
// the event kind (0 frame payload, 1 overlong frame, 2 sync) and the payload-valid flag.
module prefixed_line_frame_extractor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [plfe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [plfe_pkg::CFG_W-1:0]       cfg_wdata,
    // Input bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] byte_value
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] payload_byte
    output logic [2:0]                       m_tuser,   // [1:0] event_kind, [2] payload_valid
    output logic                             m_tlast
);

    plfe_pkg::cfg_t                      cfg_reg, cfg_next;
    plfe_pkg::beat_t                     beat;
    plfe_pkg::mem_wr_t                   mem_wr;
    logic [plfe_pkg::ADDR_W-1:0]         mem_raddr;
    logic [7:0]                          mem_rdata;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                plfe_pkg::CFG_PREFIX_BYTES: begin
                    cfg_next.prefix_bytes = cfg_wdata;
                end
                plfe_pkg::CFG_PREFIX_LENGTH: begin
                    cfg_next.prefix_length = cfg_wdata[plfe_pkg::PLEN_W-1:0];
                end
                plfe_pkg::CFG_SYNC_LENGTH: begin
                    cfg_next.sync_length = cfg_wdata[plfe_pkg::SYNC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prefix_bytes  <= '0;
            cfg_reg.prefix_length <= plfe_pkg::PLEN_W'(1);
            cfg_reg.sync_length   <= plfe_pkg::SYNC_W'(4);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    plfe_line_ram u_ram (
        .aclk  (aclk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plfe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (beat),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Pack the result beat
    assign m_tdata = beat.payload_byte;
    assign m_tuser = {beat.payload_valid, beat.kind};
    assign m_tlast = beat.last;

endmodule

[design/plfe_line_ram.sv]
// Line store: one write port, one read port with registered read data.
// Depends on plfe_pkg for geometry and the write request struct.
module plfe_line_ram (
    input  logic                          aclk,
    input  plfe_pkg::mem_wr_t             wr,
    input  logic [plfe_pkg::ADDR_W-1:0]   raddr,
    output logic [7:0]                    rdata
);

    logic [7:0] line_mem [plfe_pkg::LINE_MAX];
    logic [7:0] rd_data_reg;

    // Write on request, read every cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            line_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= line_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

[design/plfe_ctrl.sv]
// Sequencer of the extractor: zero-run sync, prefix matching, line storage
// through the line RAM, and payload and event readout into the output register.
// Depends on plfe_pkg.
module plfe_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plfe_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output plfe_pkg::beat_t               out_beat,
    output plfe_pkg::mem_wr_t             mem_wr,
    output logic [plfe_pkg::ADDR_W-1:0]   mem_raddr,
    input  logic [7:0]                    mem_rdata
);

    localparam int unsigned LEN_W   = plfe_pkg::LEN_W;
    localparam int unsigned MATCH_W = plfe_pkg::MATCH_W;
    localparam int unsigned ADDR_W  = plfe_pkg::ADDR_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECIDE = 7'b0000010,
        ST_REPLAY = 7'b0000100,
        ST_PARSE  = 7'b0001000,
        ST_CRCHK  = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_EVENT  = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        PH_SEEK    = 4'b0001,
        PH_COLLECT = 4'b0010,
        PH_IGNORE  = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

    state_t                          state_reg,    state_next;
    phase_t                          phase_reg,    phase_next;
    logic [7:0]                      byte_reg,     byte_next;
    logic [plfe_pkg::SYNC_W-1:0]     zero_run_reg, zero_run_next;
    logic [MATCH_W-1:0]              matched_reg,  matched_next;
    logic [LEN_W-1:0]                length_reg,   length_next;
    logic [LEN_W-1:0]                idx_reg,      idx_next;
    logic [LEN_W-1:0]                end_reg,      end_next;
    plfe_pkg::kind_t                 ev_kind_reg,  ev_kind_next;
    logic                            out_valid_reg, out_valid_next;
    plfe_pkg::beat_t                 out_beat_reg;

    logic                            out_free;
    logic                            push;
    plfe_pkg::beat_t                 push_beat;

    // Parse step of one byte (replayed zero or the received byte)
    logic [7:0]                      pbyte;
    logic [7:0]                      want;
    logic [MATCH_W-1:0]              in_use;
    phase_t                          ph_step;
    logic [MATCH_W-1:0]              matched_step;
    logic [LEN_W-1:0]                length_step;
    plfe_pkg::mem_wr_t               wr_step;

    // Newline and trailing CR bookkeeping
    logic [LEN_W-1:0]                start_w;
    logic [LEN_W-1:0]                end_w;
    logic [LEN_W-1:0]                end_eff;
    logic [LEN_W-1:0]                idx_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Clamp the prefix length into 1..8
    always_comb begin
        if (cfg.prefix_length == '0) begin
            in_use = MATCH_W'(1);
        end else if (cfg.prefix_length > MATCH_W'(plfe_pkg::PREFIX_MAX)) begin
            in_use = MATCH_W'(plfe_pkg::PREFIX_MAX);
        end else begin
            in_use = cfg.prefix_length;
        end
    end

    assign pbyte = (state_reg == ST_REPLAY) ? 8'h00 : byte_reg;
    assign want  = cfg.prefix_bytes[{matched_reg[2:0], 3'b000} +: 8];

    // Advance the line parser by one non-newline byte
    always_comb begin
        ph_step      = phase_reg;
        matched_step = matched_reg;
        length_step  = length_reg;
        wr_step.en   = 1'b0;
        wr_step.addr = length_reg[ADDR_W-1:0];
        wr_step.data = pbyte;
        unique case (phase_reg)
            PH_SEEK: begin
                if (pbyte != want) begin
                    ph_step = PH_IGNORE;
                end else begin
                    wr_step.en   = 1'b1;
                    length_step  = length_reg + LEN_W'(1);
                    matched_step = matched_reg + MATCH_W'(1);
                    if (matched_step >= in_use) begin
                        ph_step = PH_COLLECT;
                    end
                end
            end
            PH_COLLECT: begin
                if (length_reg < LEN_W'(plfe_pkg::LINE_MAX)) begin
                    wr_step.en  = 1'b1;
                    length_step = length_reg + LEN_W'(1);
                end else begin
                    ph_step = PH_DISCARD;
                end
            end
            PH_IGNORE: begin
            end
            PH_DISCARD: begin
            end
            default: begin
                ph_step = PH_SEEK;
            end
        endcase
    end

    assign start_w = LEN_W'(matched_reg);
    assign end_w   = (length_reg < start_w) ? start_w : length_reg;
    assign end_eff = (mem_rdata == plfe_pkg::CHAR_CR) ? (end_reg - LEN_W'(1)) : end_reg;
    assign idx_inc = idx_reg + LEN_W'(1);

    // Sequence one received byte
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        zero_run_next  = zero_run_reg;
        matched_next   = matched_reg;
        length_next    = length_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        ev_kind_next   = ev_kind_reg;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = wr_step.addr;
        mem_wr.data    = wr_step.data;
        mem_raddr      = idx_reg[ADDR_W-1:0];
        push           = 1'b0;
        push_beat.kind          = plfe_pkg::KIND_FRAME;
        push_beat.payload_byte  = 8'h00;
        push_beat.payload_valid = 1'b0;
        push_beat.last          = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    byte_next  = in_byte;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (byte_reg == 8'h00) begin
                    state_next = ST_IDLE;
                    if (zero_run_reg < cfg.sync_length) begin
                        zero_run_next = zero_run_reg + 8'd1;
                        if ((zero_run_reg + 8'd1) == cfg.sync_length) begin
                            phase_next   = PH_SEEK;
                            matched_next = '0;
                            length_next  = '0;
                            ev_kind_next = plfe_pkg::KIND_SYNC;
                            state_next   = ST_EVENT;
                        end
                    end
                end else if ((zero_run_reg < cfg.sync_length) && (zero_run_reg != '0)) begin
                    state_next = ST_REPLAY;
                end else begin
                    zero_run_next = '0;
                    state_next    = ST_PARSE;
                end
            end
            ST_REPLAY: begin
                // Feed one held-back zero per cycle; the run counter counts down
                phase_next    = ph_step;
                matched_next  = matched_step;
                length_next   = length_step;
                mem_wr        = wr_step;
                zero_run_next = zero_run_reg - 8'd1;
                if (zero_run_reg == 8'd1) begin
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE: begin
                if (byte_reg == plfe_pkg::CHAR_LF) begin
                    phase_next   = PH_SEEK;
                    matched_next = '0;
                    length_next  = '0;
                    state_next   = ST_IDLE;
                    if (phase_reg == PH_COLLECT) begin
                        if (end_w == start_w) begin
                            ev_kind_next = plfe_pkg::KIND_FRAME;
                            state_next   = ST_EVENT;
                        end else begin
                            // Fetch the final stored byte to test for CR
                            idx_next   = start_w;
                            end_next   = end_w;
                            mem_raddr  = end_w[ADDR_W-1:0] - ADDR_W'(1);
                            state_next = ST_CRCHK;
                        end
                    end else if (phase_reg == PH_DISCARD) begin
                        ev_kind_next = plfe_pkg::KIND_OVERLONG;
                        state_next   = ST_EVENT;
                    end
                end else begin
                    phase_next   = ph_step;
                    matched_next = matched_step;
                    length_next  = length_step;
                    mem_wr       = wr_step;
                    state_next   = ST_IDLE;
                end
            end
            ST_CRCHK: begin
                // Drop one trailing CR and start reading the payload
                end_next  = end_eff;
                mem_raddr = idx_reg[ADDR_W-1:0];
                if (end_eff == idx_reg) begin
                    ev_kind_next = plfe_pkg::KIND_FRAME;
                    state_next   = ST_EVENT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold the read address while stalled, else prefetch the next byte
                if (out_free) begin
                    push                    = 1'b1;
                    push_beat.kind          = plfe_pkg::KIND_FRAME;
                    push_beat.payload_byte  = mem_rdata;
                    push_beat.payload_valid = 1'b1;
                    push_beat.last          = (idx_inc == end_reg);
                    idx_next                = idx_inc;
                    mem_raddr               = idx_inc[ADDR_W-1:0];
                    if (idx_inc == end_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EVENT: begin
                if (out_free) begin
                    push           = 1'b1;
                    push_beat.kind = ev_kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (push) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SEEK;
            zero_run_reg  <= '0;
            matched_reg   <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            zero_run_reg  <= zero_run_next;
            matched_reg   <= matched_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and bookkeeping
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        ev_kind_reg <= ev_kind_next;
        if (push) begin
            out_beat_reg <= push_beat;
        end
    end

`ifndef SYNTH
    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (idx_reg < end_reg))
        else $error("payload index ran past the frame end");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (length_reg <= LEN_W'(plfe_pkg::LINE_MAX)) && (LEN_W'(matched_reg) <= length_reg))
        else $error("line length out of bounds");

    a_write_only_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> ((state_reg == ST_PARSE) || (state_reg == ST_REPLAY)))
        else $error("line store written outside a parse step");

    a_replay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPLAY) |-> (zero_run_reg != '0))
        else $error("replay entered with an empty zero run");

    a_sync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && (state_next == ST_EVENT)
            && (ev_kind_next == plfe_pkg::KIND_SYNC))
        |=> ((phase_reg == PH_SEEK) && (length_reg == '0)))
        else $error("sync event left the line open");
`endif

endmodule
